FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the noise generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Expression must never be true.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

FILE: rtl/core/nlg_pkg.sv
// Shared types, constants, microcode and helper functions of the noise generator.
package nlg_pkg;

  localparam int CYCLE_WIDTH = 8;
  localparam int LFSR_W      = 15;
  localparam int TIMER_W     = 22;
  localparam int SHIFT_W     = 4;
  localparam int DIV_W       = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int UPC_W       = 2;

  // Base period when the divider code is zero, and scale of nonzero codes.
  localparam logic [TIMER_W-1:0] BASE_MIN = TIMER_W'(8);
  localparam int DIV_SCALE_SHIFT = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_SHIFT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MODE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_CODE = CFG_INDEX_W'(2);

  // Microcode step addresses.
  localparam logic [UPC_W-1:0] STEP_ACCEPT = UPC_W'(0);
  localparam logic [UPC_W-1:0] STEP_TRIG   = UPC_W'(1);
  localparam logic [UPC_W-1:0] STEP_SPEND  = UPC_W'(2);
  localparam logic [UPC_W-1:0] STEP_EMIT   = UPC_W'(3);

  // Datapath operation of a step.
  typedef enum logic [1:0] {
    OP_ACCEPT = 2'd0,
    OP_TRIG   = 2'd1,
    OP_SPEND  = 2'd2,
    OP_EMIT   = 2'd3
  } op_t;

  // Jump condition of a step.
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_REQ   = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Strobes from sequencer to datapath.
  typedef struct packed {
    logic ready;
    logic accept;
    logic trig;
    logic spend;
    logic emit;
  } ctrl_t;

  // Flags from datapath back to sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic more;
  } status_t;

  // Control store: taken jump goes to target, otherwise to the next step.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    unique case (upc)
      STEP_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_NO_REQ,   target: STEP_ACCEPT};
      STEP_TRIG:   w = '{op: OP_TRIG,   cond: COND_NEVER,    target: STEP_ACCEPT};
      STEP_SPEND:  w = '{op: OP_SPEND,  cond: COND_MORE,     target: STEP_SPEND};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: STEP_EMIT};
    endcase
    return w;
  endfunction

  // Timer reload value: base period shifted by the clock shift.
  function automatic logic [TIMER_W-1:0] period_of(input logic [SHIFT_W-1:0] shift,
                                                   input logic [DIV_W-1:0]   div);
    logic [TIMER_W-1:0] base;
    base = (div != '0) ? (TIMER_W'(div) << DIV_SCALE_SHIFT) : BASE_MIN;
    return base << shift;
  endfunction

  // One LFSR step: XNOR of bits 0 and 1 enters at the top (and bit 6 in short mode).
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l,
                                                  input logic              short_mode);
    logic x;
    x = ~(l[0] ^ l[1]);
    return short_mode ? {x, l[14:8], x, l[6:1]} : {x, l[14:1]};
  endfunction

endpackage

FILE: rtl/core/noise_lfsr_generator_core.sv
// Noise generator top level: 15/7-bit LFSR clocked by a programmable period timer.
//
// Input channel (in_valid/in_ready): each request carries the clock cycles elapsed
// since the previous one and a trigger flag; a trigger clears the LFSR and reloads
// the period timer before the cycles are counted.
// Output channel (out_valid/out_ready): one result per request, the LFSR bit 0
// (noise_bit) and the full LFSR (lfsr_value) after the request.
// Config port: cfg_wr_en writes cfg_data to register cfg_index (0 clock_shift,
// 1 short_mode, 2 divider_code); other indexes are ignored. Write only when idle.
// Timing: one request at a time, run by a four-step microcode sequencer. A request
// makes n spend passes: one per timer expiry inside the request plus one for any
// remainder, at least 1 and at most 33 with 8-bit cycle counts. The spend loop is
// one compare-and-subtract of the 22-bit timer per cycle.
// in_ready is high only in the accept step, which follows the result step, so the
// next request is taken only after the previous result is loaded into the output
// register.
// Stall: a pending result waits in the output register; a new result waits at the
// result step until the register is free, holding off further requests.
// Reset: LFSR, timer and config registers clear; no result is pending.

module noise_lfsr_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [nlg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nlg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nlg_pkg::CYCLE_WIDTH-1:0]   cycles,
  input  logic                              trigger,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              noise_bit,
  output logic [nlg_pkg::LFSR_W-1:0]        lfsr_value
);
  import nlg_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Control sequencer
  nlg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Datapath
  nlg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .cycles     (cycles),
    .trigger    (trigger),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .noise_bit  (noise_bit),
    .lfsr_value (lfsr_value)
  );

  assign in_ready = ctrl.ready;

endmodule

FILE: rtl/core/nlg_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`include "assert_macros.svh"

module nlg_seq (
  input  logic            clk,
  input  logic            rst,
  input  nlg_pkg::status_t status,
  output nlg_pkg::ctrl_t   ctrl
);
  import nlg_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ucode_t           uword;
  logic             jump;

  assign uword = ucode_rom(upc);

  // Evaluate the jump condition
  always_comb begin
    unique case (uword.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_REQ:   jump = ~status.in_valid;
      COND_MORE:     jump = status.more;
      COND_OUT_BUSY: jump = status.out_busy;
    endcase
  end

  // Step counter wraps from the last step back to the accept step
  assign upc_next = jump ? uword.target : upc + UPC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_ACCEPT;
    end else begin
      upc <= upc_next;
    end
  end

  // Decode the control word into datapath strobes
  always_comb begin
    ctrl.ready  = (uword.op == OP_ACCEPT);
    ctrl.accept = (uword.op == OP_ACCEPT) && status.in_valid;
    ctrl.trig   = (uword.op == OP_TRIG);
    ctrl.spend  = (uword.op == OP_SPEND);
    ctrl.emit   = (uword.op == OP_EMIT) && !status.out_busy;
  end

  `ASSERT_CLK(a_accept_to_trig, clk, rst, ctrl.accept |=> upc == STEP_TRIG, "accepted request did not advance to trigger step")
  `ASSERT_CLK(a_emit_holds, clk, rst, (upc == STEP_EMIT && status.out_busy) |=> upc == STEP_EMIT, "result step left while output busy")

endmodule

FILE: rtl/core/nlg_dp.sv
// Datapath: config registers, cycle counter, period timer, LFSR and output register.
`include "assert_macros.svh"

module nlg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  nlg_pkg::ctrl_t                    ctrl,
  output nlg_pkg::status_t                  status,
  input  logic                              cfg_wr_en,
  input  logic [nlg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nlg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic [nlg_pkg::CYCLE_WIDTH-1:0]   cycles,
  input  logic                              trigger,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              noise_bit,
  output logic [nlg_pkg::LFSR_W-1:0]        lfsr_value
);
  import nlg_pkg::*;

  logic [SHIFT_W-1:0]     clock_shift;
  logic                   short_mode;
  logic [DIV_W-1:0]       divider_code;
  logic [CYCLE_WIDTH-1:0] rem;
  logic [CYCLE_WIDTH-1:0] rem_next;
  logic [TIMER_W-1:0]     timer;
  logic [TIMER_W-1:0]     timer_left;
  logic [TIMER_W-1:0]     period;
  logic [LFSR_W-1:0]      lfsr;
  logic [LFSR_W-1:0]      out_lfsr;
  logic                   trig_r;
  logic                   live;
  logic                   hit;

  assign period = period_of(clock_shift, divider_code);
  assign live   = ctrl.spend && (rem != '0);

  // One spend pass: drain the timer or the pending cycles, whichever is smaller
  always_comb begin
    if (TIMER_W'(rem) > timer) begin
      rem_next   = rem - timer[CYCLE_WIDTH-1:0];
      timer_left = '0;
      hit        = 1'b1;
    end else begin
      rem_next   = '0;
      timer_left = timer - TIMER_W'(rem);
      hit        = (timer_left == '0);
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_shift  <= '0;
      short_mode   <= 1'b0;
      divider_code <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CLOCK_SHIFT:  clock_shift  <= cfg_data[SHIFT_W-1:0];
        REG_SHORT_MODE:   short_mode   <= cfg_data[0];
        REG_DIVIDER_CODE: divider_code <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Counter, timer and LFSR
  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= '0;
      timer <= '0;
      lfsr  <= '0;
    end else if (ctrl.accept) begin
      rem <= cycles;
    end else if (ctrl.trig && trig_r) begin
      lfsr  <= '0;
      timer <= period;
    end else if (live) begin
      rem   <= rem_next;
      timer <= hit ? period : timer_left;
      if (hit) begin
        lfsr <= lfsr_step(lfsr, short_mode);
      end
    end
  end

  // Trigger flag of the request in flight
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      trig_r <= trigger;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_lfsr <= lfsr;
    end
  end

  assign noise_bit  = out_lfsr[0];
  assign lfsr_value = out_lfsr;

  always_comb begin
    status.in_valid = in_valid;
    status.out_busy = out_valid && !out_ready;
    status.more     = live && (rem_next != '0);
  end

  `ASSERT_CLK(a_spend_timer_live, clk, rst, live |=> timer != '0, "timer zero after a spend pass")
  `ASSERT_CLK(a_trig_clears, clk, rst, (ctrl.trig && trig_r) |=> (lfsr == '0 && timer != '0), "trigger did not restart channel")
  `ASSERT_CLK(a_idle_no_cycles, clk, rst, ctrl.ready |-> rem == '0, "cycles left over at accept step")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the noise LFSR generator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nlg_pkg::*;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
  localparam int IDLE_PCT      = 18;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_COUNT = 540;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic              tap;
    logic [LFSR_W-1:0] value;
  } outcome_t;

  // Tracks channel state, predicts one outcome per request and checks results
  class lfsr_tracker;
    logic [SHIFT_W-1:0] shift;
    logic               short_fb;
    logic [DIV_W-1:0]   div;
    logic [LFSR_W-1:0]  lfsr;
    logic [TIMER_W-1:0] timer;
    outcome_t           outcomes[$];
    int                 errors;
    int                 checked;

    function new();
      shift    = '0;
      short_fb = 1'b0;
      div      = '0;
      lfsr     = '0;
      timer    = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CLOCK_SHIFT:  shift    = data[SHIFT_W-1:0];
        REG_SHORT_MODE:   short_fb = data[0];
        REG_DIVIDER_CODE: div      = data[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    // Reload value from the current register settings
    function logic [TIMER_W-1:0] reload_value();
      logic [TIMER_W-1:0] base;
      base = (div == '0) ? TIMER_W'(8) : TIMER_W'(div) * TIMER_W'(16);
      return base << shift;
    endfunction

    function void note_request(input logic [CYCLE_WIDTH-1:0] cyc, input logic trig);
      int unsigned left;
      logic        fb;
      outcome_t    o;
      left = cyc;
      if (trig) begin
        lfsr  = '0;
        timer = reload_value();
      end
      while (left > 0) begin
        if (left > timer) begin
          left  -= timer;
          timer = '0;
        end else begin
          timer = timer - TIMER_W'(left);
          left  = 0;
        end
        // expiry: reload and shift once, feedback into the top (and bit 6 in short mode)
        if (timer == '0) begin
          timer = reload_value();
          fb = lfsr[0] ~^ lfsr[1];
          lfsr = lfsr >> 1;
          lfsr[LFSR_W-1] = fb;
          if (short_fb) lfsr[6] = fb;
        end
      end
      o.tap   = lfsr[0];
      o.value = lfsr;
      outcomes.push_back(o);
    endfunction

    function void check_result(input logic tap, input logic [LFSR_W-1:0] value);
      outcome_t o;
      checked++;
      if (outcomes.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result %0d arrived with nothing expected: noise_bit %b lfsr_value %h",
                   checked, tap, value);
      end else begin
        o = outcomes.pop_front();
        if (o.tap !== tap || o.value !== value) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("result %0d: noise_bit exp %b got %b, lfsr_value exp %h got %h",
                     checked, o.tap, tap, o.value, value);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [CYCLE_WIDTH-1:0] cycles;
  logic                   trigger;
  logic                   out_valid;
  logic                   out_ready;
  logic                   noise_bit;
  logic [LFSR_W-1:0]      lfsr_value;

  lfsr_tracker tracker = new();
  bit          steady;
  int          quiet_cycles;

  noise_lfsr_generator_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cycles     (cycles),
    .trigger    (trigger),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .noise_bit  (noise_bit),
    .lfsr_value (lfsr_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(noise_bit, lfsr_value);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result sink: random stalls, one long hold-off to back up the core
  initial begin : result_sink
    bit held;
    int k;
    held = 1'b0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && tracker.checked >= HOLD_AT_COUNT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [CYCLE_WIDTH-1:0] cyc, input logic trig);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cycles   <= cyc;
    trigger  <= trig;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(cyc, trig);
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] sm,
                           input logic [CFG_DATA_W-1:0] dv, input bit poke_unused);
    wait_idle();
    write_reg(REG_CLOCK_SHIFT, sh);
    write_reg(REG_SHORT_MODE, sm);
    write_reg(REG_DIVIDER_CODE, dv);
    if (poke_unused) write_reg(REG_UNUSED, '1);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int n;
    int i;
    int roll;
    logic [CYCLE_WIDTH-1:0] cyc;

    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cycles    <= '0;
    trigger   <= 1'b0;
    steady    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, period 8: zero timer stays put, then steps at once on cycles
    send_request(8'd0, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd0, 1'b1);
    send_request(8'd255, 1'b1);
    send_request(8'd8, 1'b0);
    send_request(8'd7, 1'b0);
    send_request(8'd1, 1'b0);
    send_request(8'hAA, 1'b0);
    send_request(8'h55, 1'b0);

    // Short mode via an over-wide value, top divider via masking, unused index poked
    configure(4'd0, 4'b0011, 4'hF, 1'b1);
    send_request(8'd255, 1'b1);
    send_request(8'd255, 1'b0);
    send_request(8'd112, 1'b0);
    send_request(8'd0, 1'b1);
    send_request(8'd255, 1'b0);

    // Longest period: timer runs across many requests
    configure(4'hF, 4'b1110, 4'd7, 1'b0);
    send_request(8'd255, 1'b1);
    send_request(8'd128, 1'b0);
    send_request(8'd255, 1'b0);

    // Shortest period in short mode
    configure(4'd0, 4'd1, 4'd0, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd255, 1'b0);
    send_request(8'd1, 1'b1);
    send_request(8'd255, 1'b0);

    // Random phases; phase 0 at the minimum settings, phase 1 at the maximum
    for (p = 0; p < 8; p++) begin
      if (p == 0) configure(4'd0, 4'd0, 4'd0, 1'b1);
      else if (p == 1) configure(4'hF, 4'd1, 4'd7, 1'b0);
      else configure(4'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
      steady = (p == 4);
      n = (p == 1) ? 40 : 170;
      for (i = 0; i < n; i++) begin
        roll = $urandom_range(0, 7);
        if (roll == 0) cyc = '0;
        else if (roll == 1) cyc = '1;
        else cyc = CYCLE_WIDTH'($urandom_range(0, 255));
        send_request(cyc, $urandom_range(0, 11) == 0);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/nlg_pkg.sv
rtl/core/nlg_seq.sv
rtl/core/nlg_dp.sv
rtl/core/noise_lfsr_generator_core.sv
tb/testbench.sv
